/* hw/rtl/grrq_pkg.sv */
`timescale 1ns / 1ps
// Package for the grouped round-robin run queues block.
// Sizes, payload structs, codes and controller/datapath interface types; no dependencies.
package grrq_pkg;

    localparam int MAX_THREADS = 64;
    localparam int MAX_GROUPS  = 16;

    localparam int TID_W  = 15;
    localparam int KEY_W  = 16;
    localparam int SLOT_W = $clog2(MAX_THREADS);
    localparam int GRP_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CNT_W  = $clog2(MAX_THREADS + 1);
    localparam int SCAN_N = (MAX_THREADS > MAX_GROUPS) ? MAX_THREADS : MAX_GROUPS;
    localparam int SCAN_W = $clog2(SCAN_N + 1);

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_DELETE = 2'd1,
        OP_SWITCH = 2'd2
    } opcode_e;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOGRP   = 2'd2,
        ST_IGNORED = 2'd3
    } status_e;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [TID_W-1:0] thread_id;
        logic             is_group_leader;
        logic [KEY_W-1:0] group_key;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             wake_valid;
        logic [TID_W-1:0] wake_thread;
        logic             caller_sleeps;
        logic             group_removed;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CSCAN,
        S_CDEC,
        S_CAPP,
        S_FSCAN,
        S_FDEC,
        S_GWAIT,
        S_GDEC,
        S_NWAIT,
        S_TWAIT,
        S_DONE
    } state_e;

    typedef struct packed {
        logic load;
        logic cscan;
        logic cdec;
        logic capp;
        logic fscan;
        logic fdec;
        logic gload;
        logic gdec;
        logic nload;
        logic tload;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic is_create;
        logic is_find;
        logic cscan_last;
        logic find_done;
        logic found;
        logic append;
        logic need_next;
        logic out_free;
    } stat_t;

endpackage

/* hw/rtl/grrq_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module grrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/grrq_ctrl.sv */
`timescale 1ns / 1ps
// Controller FSM for the run queues: sequences scans and table updates.
// Depends on grrq_pkg.
module grrq_ctrl
    import grrq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_e state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (stat.is_create) state_next = S_CSCAN;
                else if (stat.is_find)       state_next = S_FSCAN;
                else                         state_next = S_DONE;
            end
            S_CSCAN:
            begin
                cmd.cscan = 1'b1;
                if (stat.cscan_last)
                begin
                    state_next = S_CDEC;
                end
            end
            S_CDEC:
            begin
                cmd.cdec   = 1'b1;
                state_next = stat.append ? S_CAPP : S_DONE;
            end
            S_CAPP:
            begin
                cmd.capp   = 1'b1;
                state_next = S_DONE;
            end
            S_FSCAN:
            begin
                if (stat.find_done)
                begin
                    state_next = S_FDEC;
                end
                else
                begin
                    cmd.fscan = 1'b1;
                end
            end
            S_FDEC:
            begin
                cmd.fdec   = 1'b1;
                state_next = stat.found ? S_GWAIT : S_DONE;
            end
            S_GWAIT:
            begin
                cmd.gload  = 1'b1;
                state_next = S_GDEC;
            end
            S_GDEC:
            begin
                cmd.gdec   = 1'b1;
                state_next = stat.need_next ? S_NWAIT : S_DONE;
            end
            S_NWAIT:
            begin
                cmd.nload  = 1'b1;
                state_next = S_TWAIT;
            end
            S_TWAIT:
            begin
                cmd.tload  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/grrq_dp.sv */
`timescale 1ns / 1ps
// Datapath for the run queues: slot RAMs, group tables, scan counter, result registers.
// Depends on grrq_pkg and grrq_ram.
module grrq_dp
    import grrq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    output stat_t stat,
    input  req_t  req,
    output logic  rsp_valid,
    input  logic  rsp_ready,
    output rsp_t  rsp
);

    // control state
    logic [SCAN_W-1:0]      cnt_reg, cnt_next;
    logic                   fs_ok_reg, fs_ok_next;
    logic                   mg_ok_reg, mg_ok_next;
    logic                   fg_ok_reg, fg_ok_next;
    logic                   pv_reg, pv_next;
    logic                   found_reg, found_next;
    logic                   exh_reg, exh_next;
    logic                   out_valid_reg, out_valid_next;
    logic [MAX_THREADS-1:0] used_reg, used_next;
    logic [MAX_GROUPS-1:0]  gused_reg, gused_next;
    logic [CNT_W-1:0]       gcount_reg [MAX_GROUPS];
    logic [CNT_W-1:0]       gcount_next [MAX_GROUPS];

    // payload
    req_t                   req_reg, req_next;
    logic [SLOT_W-1:0]      fs_reg, fs_next;
    logic [GRP_W-1:0]       mg_reg, mg_next;
    logic [GRP_W-1:0]       fg_reg, fg_next;
    logic [SLOT_W-1:0]      pidx_reg, pidx_next;
    logic [SLOT_W-1:0]      s_reg, s_next;
    logic [GRP_W-1:0]       g_reg, g_next;
    logic [SLOT_W-1:0]      h_reg, h_next;
    logic [SLOT_W-1:0]      t_reg, t_next;
    rsp_t                   res_reg, res_next;
    rsp_t                   out_reg, out_next;
    logic [KEY_W-1:0]       gkey_reg [MAX_GROUPS];
    logic [KEY_W-1:0]       gkey_next [MAX_GROUPS];
    logic [SLOT_W-1:0]      ghead_reg [MAX_GROUPS];
    logic [SLOT_W-1:0]      ghead_next [MAX_GROUPS];
    logic [SLOT_W-1:0]      gtail_reg [MAX_GROUPS];
    logic [SLOT_W-1:0]      gtail_next [MAX_GROUPS];

    // RAM ports
    logic                   thr_we, grp_we, nxt_we;
    logic [SLOT_W-1:0]      thr_waddr, grp_waddr, nxt_waddr;
    logic [SLOT_W-1:0]      thr_raddr;
    logic [TID_W-1:0]       thr_wdata, thr_rdata;
    logic [GRP_W-1:0]       grp_wdata, grp_rdata;
    logic [SLOT_W-1:0]      nxt_wdata, nxt_rdata;

    // group table read port (one index per cycle)
    logic [GRP_W-1:0]       gi;
    logic [KEY_W-1:0]       gi_key;
    logic [SLOT_W-1:0]      gi_head, gi_tail;
    logic [CNT_W-1:0]       gi_count;
    logic                   gi_used;

    logic                   in_slot, in_grp, is_switch, new_slot;

    grrq_ram #(.WIDTH(TID_W), .DEPTH(MAX_THREADS)) u_thr_ram (
        .clk   (clk),
        .we    (thr_we),
        .waddr (thr_waddr),
        .wdata (thr_wdata),
        .raddr (thr_raddr),
        .rdata (thr_rdata)
    );

    grrq_ram #(.WIDTH(GRP_W), .DEPTH(MAX_THREADS)) u_grp_ram (
        .clk   (clk),
        .we    (grp_we),
        .waddr (grp_waddr),
        .wdata (grp_wdata),
        .raddr (s_reg),
        .rdata (grp_rdata)
    );

    grrq_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_THREADS)) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (gi_head),
        .rdata (nxt_rdata)
    );

    always_comb
    begin
        priority if (cmd.cscan) gi = cnt_reg[GRP_W-1:0];
        else if (cmd.cdec)      gi = mg_reg;
        else                    gi = g_reg;
    end

    assign gi_key    = gkey_reg[gi];
    assign gi_head   = ghead_reg[gi];
    assign gi_tail   = gtail_reg[gi];
    assign gi_count  = gcount_reg[gi];
    assign gi_used   = gused_reg[gi];
    assign in_slot   = cnt_reg < SCAN_W'(MAX_THREADS);
    assign in_grp    = cnt_reg < SCAN_W'(MAX_GROUPS);
    assign is_switch = req_reg.opcode == OP_SWITCH;
    assign new_slot  = cmd.cdec && fs_ok_reg && (mg_ok_reg || fg_ok_reg);

    // thread RAM: scan address, otherwise the new head from the next RAM
    assign thr_raddr = cmd.fscan ? cnt_reg[SLOT_W-1:0] : nxt_rdata;
    assign thr_we    = new_slot;
    assign thr_waddr = fs_reg;
    assign thr_wdata = req_reg.thread_id;
    assign grp_we    = new_slot;
    assign grp_waddr = fs_reg;
    assign grp_wdata = mg_ok_reg ? mg_reg : fg_reg;

    always_comb
    begin
        nxt_we    = 1'b0;
        nxt_waddr = fs_reg;
        nxt_wdata = '0;
        priority if (new_slot)
        begin
            nxt_we = 1'b1;
        end
        else if (cmd.capp)
        begin
            nxt_we    = 1'b1;
            nxt_waddr = t_reg;
            nxt_wdata = fs_reg;
        end
        else if (cmd.nload && is_switch)
        begin
            nxt_we    = 1'b1;
            nxt_waddr = gi_tail;
            nxt_wdata = h_reg;
        end
        else
        begin
            nxt_we = 1'b0;
        end
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        fs_ok_next     = fs_ok_reg;
        mg_ok_next     = mg_ok_reg;
        fg_ok_next     = fg_ok_reg;
        pv_next        = 1'b0;
        found_next     = found_reg;
        exh_next       = exh_reg;
        out_valid_next = out_valid_reg;
        used_next      = used_reg;
        gused_next     = gused_reg;
        gcount_next    = gcount_reg;
        req_next       = req_reg;
        fs_next        = fs_reg;
        mg_next        = mg_reg;
        fg_next        = fg_reg;
        pidx_next      = pidx_reg;
        s_next         = s_reg;
        g_next         = g_reg;
        h_next         = h_reg;
        t_next         = t_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        gkey_next      = gkey_reg;
        ghead_next     = ghead_reg;
        gtail_next     = gtail_reg;

        if (cmd.load)
        begin
            req_next   = req;
            cnt_next   = '0;
            fs_ok_next = 1'b0;
            mg_ok_next = 1'b0;
            fg_ok_next = 1'b0;
            found_next = 1'b0;
            exh_next   = 1'b0;
            res_next   = '0;
            if (!(req.opcode == OP_CREATE || req.opcode == OP_DELETE
                  || (req.opcode == OP_SWITCH && !req.is_group_leader)))
            begin
                res_next.status = ST_IGNORED;
            end
        end

        // create scan: free slot, matching group and free group in one pass
        if (cmd.cscan)
        begin
            if (in_slot && !fs_ok_reg && !used_reg[cnt_reg[SLOT_W-1:0]])
            begin
                fs_ok_next = 1'b1;
                fs_next    = cnt_reg[SLOT_W-1:0];
            end
            if (in_grp && !mg_ok_reg && gi_used && gi_key == req_reg.group_key)
            begin
                mg_ok_next = 1'b1;
                mg_next    = gi;
            end
            if (in_grp && !fg_ok_reg && !gi_used)
            begin
                fg_ok_next = 1'b1;
                fg_next    = gi;
            end
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.cdec)
        begin
            if (!fs_ok_reg || (!mg_ok_reg && !fg_ok_reg))
            begin
                res_next.status = ST_FULL;
            end
            else if (mg_ok_reg)
            begin
                used_next[fs_reg]    = 1'b1;
                t_next               = gi_tail;
                gtail_next[mg_reg]   = fs_reg;
                gcount_next[mg_reg]  = gi_count + 1'b1;
                res_next.caller_sleeps = 1'b1;
            end
            else
            begin
                used_next[fs_reg]   = 1'b1;
                gkey_next[fg_reg]   = req_reg.group_key;
                ghead_next[fg_reg]  = fs_reg;
                gtail_next[fg_reg]  = fs_reg;
                gcount_next[fg_reg] = CNT_W'(1);
                gused_next[fg_reg]  = 1'b1;
            end
        end

        // thread search: read issued one cycle, compared the next
        if (cmd.fscan)
        begin
            pv_next   = in_slot;
            pidx_next = cnt_reg[SLOT_W-1:0];
            if (in_slot)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (pv_reg && !found_reg && used_reg[pidx_reg]
            && thr_rdata == req_reg.thread_id)
        begin
            found_next = 1'b1;
            s_next     = pidx_reg;
        end
        if (pv_reg && pidx_reg == SLOT_W'(MAX_THREADS - 1))
        begin
            exh_next = 1'b1;
        end

        if (cmd.fdec && !found_reg)
        begin
            res_next.status = ST_NOGRP;
        end

        if (cmd.gload)
        begin
            g_next = grp_rdata;
        end

        if (cmd.gdec)
        begin
            h_next = gi_head;
            if (!is_switch)
            begin
                used_next[gi_head] = 1'b0;
                if (gi_count <= CNT_W'(1))
                begin
                    gcount_next[g_reg]     = '0;
                    gused_next[g_reg]      = 1'b0;
                    res_next.group_removed = 1'b1;
                end
            end
        end

        if (cmd.nload)
        begin
            ghead_next[g_reg]   = nxt_rdata;
            res_next.wake_valid = 1'b1;
            if (is_switch)
            begin
                gtail_next[g_reg]      = h_reg;
                res_next.caller_sleeps = 1'b1;
            end
            else
            begin
                gcount_next[g_reg] = gi_count - 1'b1;
            end
        end

        if (cmd.tload)
        begin
            res_next.wake_thread = thr_rdata;
        end

        if (cmd.emit)
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            fs_ok_reg     <= 1'b0;
            mg_ok_reg     <= 1'b0;
            fg_ok_reg     <= 1'b0;
            pv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            exh_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            used_reg      <= '0;
            gused_reg     <= '0;
            for (int i = 0; i < MAX_GROUPS; i++)
            begin
                gcount_reg[i] <= '0;
            end
        end
        else
        begin
            cnt_reg       <= cnt_next;
            fs_ok_reg     <= fs_ok_next;
            mg_ok_reg     <= mg_ok_next;
            fg_ok_reg     <= fg_ok_next;
            pv_reg        <= pv_next;
            found_reg     <= found_next;
            exh_reg       <= exh_next;
            out_valid_reg <= out_valid_next;
            used_reg      <= used_next;
            gused_reg     <= gused_next;
            gcount_reg    <= gcount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        fs_reg    <= fs_next;
        mg_reg    <= mg_next;
        fg_reg    <= fg_next;
        pidx_reg  <= pidx_next;
        s_reg     <= s_next;
        g_reg     <= g_next;
        h_reg     <= h_next;
        t_reg     <= t_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
        gkey_reg  <= gkey_next;
        ghead_reg <= ghead_next;
        gtail_reg <= gtail_next;
    end

    assign stat.is_create  = req_reg.opcode == OP_CREATE;
    assign stat.is_find    = req_reg.opcode == OP_DELETE
                             || (is_switch && !req_reg.is_group_leader);
    assign stat.cscan_last = cnt_reg == SCAN_W'(SCAN_N - 1);
    assign stat.find_done  = found_reg || exh_reg;
    assign stat.found      = found_reg;
    assign stat.append     = fs_ok_reg && mg_ok_reg;
    assign stat.need_next  = gi_count >= CNT_W'(2);
    assign stat.out_free   = !out_valid_reg || rsp_ready;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

/* hw/rtl/grouped_round_robin_run_queues.sv */
`timescale 1ns / 1ps
// Create: one pass over max(MAX_THREADS, MAX_GROUPS) entries, then the table update and, on a join, the append.
// Delete/switch: search of the thread RAM, one slot per cycle, then reads of the group, next slot and woken thread.
// One request at a time; the next is taken while the last result waits in the output register.
// Reset (async, active low) empties all groups and slots at once; no clearing pass.
// Depends on grrq_pkg, grrq_ctrl, grrq_dp, grrq_ram.
module grouped_round_robin_run_queues
    import grrq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    cmd_t  cmd;
    stat_t stat;

    grrq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    grrq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

/* hw/rtl/grrq_checker.sv */
`timescale 1ns / 1ps
// Port-level checks on the run queue results, bound to the top level.
// Depends on grrq_pkg.
module grrq_checker
    import grrq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    a_wake_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.wake_valid |-> rsp.wake_thread == '0)
        else $error("wake thread set without wake");

    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK
        |-> !rsp.wake_valid && !rsp.caller_sleeps && !rsp.group_removed)
        else $error("flags set on error result");

    a_removed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.group_removed |-> !rsp.wake_valid && !rsp.caller_sleeps)
        else $error("removed group also wakes or sleeps");

endmodule

bind grouped_round_robin_run_queues grrq_checker u_grrq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Testbench for grouped_round_robin_run_queues: directed and random scheduler commands,
// checked against an in-bench model of the group tables. Depends on grrq_pkg and the RTL.
module tb;
    import grrq_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam logic [1:0] OP_BAD = 2'd3;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    grouped_round_robin_run_queues u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // scheduler table model
    logic [TID_W-1:0]  q_thread [MAX_THREADS];
    logic [SLOT_W-1:0] q_next   [MAX_THREADS];
    logic [GRP_W-1:0]  q_group  [MAX_THREADS];
    logic              q_used   [MAX_THREADS];
    logic [KEY_W-1:0]  g_key    [MAX_GROUPS];
    logic [SLOT_W-1:0] g_head   [MAX_GROUPS];
    logic [SLOT_W-1:0] g_tail   [MAX_GROUPS];
    int                g_count  [MAX_GROUPS];
    logic              g_used   [MAX_GROUPS];

    rsp_t expected_rsps[$];
    int   errors = 0;
    int   n_sent = 0;
    int   n_rcvd = 0;
    int   n_full = 0;
    int   n_nogrp = 0;
    int   n_wake = 0;
    int   n_removed = 0;
    int   cycles = 0;
    bit   hold_off = 0;
    bit   stall_on = 1;

    // live thread ids, for picking callers that are in some group
    logic [TID_W-1:0] live_tids[$];

    function automatic rsp_t schedule_cmd(req_t r);
        rsp_t o;
        int s;
        int g;
        int fg;
        int h;
        int t;
        int nh;
        o = '0;
        o.status = ST_OK;
        if (r.opcode == OP_CREATE)
        begin
            g = -1;
            s = -1;
            fg = -1;
            for (int i = 0; i < MAX_GROUPS; i++)
                if (g < 0 && g_used[i] && g_key[i] == r.group_key) g = i;
            for (int i = 0; i < MAX_THREADS; i++)
                if (s < 0 && !q_used[i]) s = i;
            for (int i = 0; i < MAX_GROUPS; i++)
                if (fg < 0 && !g_used[i]) fg = i;
            if (s < 0 || (g < 0 && fg < 0))
            begin
                o.status = ST_FULL;
            end
            else
            begin
                q_thread[s] = r.thread_id;
                q_next[s] = '0;
                q_used[s] = 1'b1;
                if (g >= 0)
                begin
                    q_group[s] = GRP_W'(g);
                    q_next[g_tail[g]] = SLOT_W'(s);
                    g_tail[g] = SLOT_W'(s);
                    g_count[g]++;
                    o.caller_sleeps = 1'b1;
                end
                else
                begin
                    q_group[s] = GRP_W'(fg);
                    g_key[fg] = r.group_key;
                    g_head[fg] = SLOT_W'(s);
                    g_tail[fg] = SLOT_W'(s);
                    g_count[fg] = 1;
                    g_used[fg] = 1'b1;
                end
            end
        end
        else if (r.opcode == OP_DELETE
                 || (r.opcode == OP_SWITCH && !r.is_group_leader))
        begin
            s = -1;
            for (int i = 0; i < MAX_THREADS; i++)
                if (s < 0 && q_used[i] && q_thread[i] == r.thread_id) s = i;
            if (s < 0)
            begin
                o.status = ST_NOGRP;
            end
            else
            begin
                g = q_group[s];
                h = g_head[g];
                if (r.opcode == OP_DELETE)
                begin
                    q_used[h] = 1'b0;
                    if (g_count[g] <= 1)
                    begin
                        g_count[g] = 0;
                        g_used[g] = 1'b0;
                        o.group_removed = 1'b1;
                    end
                    else
                    begin
                        nh = q_next[h];
                        g_count[g]--;
                        g_head[g] = SLOT_W'(nh);
                        o.wake_valid = 1'b1;
                        o.wake_thread = q_thread[nh];
                    end
                end
                else if (g_count[g] >= 2)
                begin
                    t = g_tail[g];
                    nh = q_next[h];
                    q_next[t] = SLOT_W'(h);
                    g_tail[g] = SLOT_W'(h);
                    g_head[g] = SLOT_W'(nh);
                    o.wake_valid = 1'b1;
                    o.wake_thread = q_thread[nh];
                    o.caller_sleeps = 1'b1;
                end
            end
        end
        else
        begin
            o.status = ST_IGNORED;
        end
        return o;
    endfunction

    task automatic refresh_live_tids();
        live_tids.delete();
        for (int i = 0; i < MAX_THREADS; i++)
            if (q_used[i]) live_tids.push_back(q_thread[i]);
    endtask

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver stall pattern; hold_off forces a long stall
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            rsp_ready <= 1'b0;
        else if (stall_on)
            rsp_ready <= ($urandom_range(0, 3) != 0);
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            n_rcvd++;
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected response %p", rsp);
                errors++;
            end
            else
            begin
                exp_rsp = expected_rsps.pop_front();
                if (rsp.status != exp_rsp.status)
                begin
                    $error("status exp %0d got %0d", exp_rsp.status, rsp.status);
                    errors++;
                end
                if (rsp.wake_valid != exp_rsp.wake_valid)
                begin
                    $error("wake_valid exp %0d got %0d", exp_rsp.wake_valid, rsp.wake_valid);
                    errors++;
                end
                if (rsp.wake_thread != exp_rsp.wake_thread)
                begin
                    $error("wake_thread exp %0d got %0d", exp_rsp.wake_thread,
                           rsp.wake_thread);
                    errors++;
                end
                if (rsp.caller_sleeps != exp_rsp.caller_sleeps)
                begin
                    $error("caller_sleeps exp %0d got %0d", exp_rsp.caller_sleeps,
                           rsp.caller_sleeps);
                    errors++;
                end
                if (rsp.group_removed != exp_rsp.group_removed)
                begin
                    $error("group_removed exp %0d got %0d", exp_rsp.group_removed,
                           rsp.group_removed);
                    errors++;
                end
            end
        end
    end

    // drives one request, waits for the handshake, records the prediction;
    // returns at the next falling edge with valid still high
    task automatic send_cmd(logic [1:0] op, logic [TID_W-1:0] tid, logic leader,
                            logic [KEY_W-1:0] key);
        rsp_t p;
        req_valid <= 1'b1;
        req.opcode <= op;
        req.thread_id <= tid;
        req.is_group_leader <= leader;
        req.group_key <= key;
        do @(posedge clk); while (!req_ready);
        p = schedule_cmd('{opcode: op, thread_id: tid, is_group_leader: leader,
                           group_key: key});
        expected_rsps.push_back(p);
        n_sent++;
        if (p.status == ST_FULL) n_full++;
        if (p.status == ST_NOGRP) n_nogrp++;
        if (p.wake_valid) n_wake++;
        if (p.group_removed) n_removed++;
        @(negedge clk);
    endtask

    task automatic pause_cycles(int n);
        req_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (expected_rsps.size() != 0) @(negedge clk);
    endtask

    // random caller: mostly a live thread, sometimes any id
    function automatic logic [TID_W-1:0] pick_tid();
        if (live_tids.size() != 0 && $urandom_range(0, 9) < 8)
            return live_tids[$urandom_range(0, live_tids.size() - 1)];
        return TID_W'($urandom_range(0, 32767));
    endfunction

    task automatic test_directed();
        send_cmd(OP_DELETE, 15'h7fff, 1'b0, 16'h0);       // no group
        send_cmd(OP_SWITCH, 15'h0, 1'b0, 16'h0);          // no group
        send_cmd(OP_CREATE, 15'h0, 1'b1, 16'hffff);       // new group
        send_cmd(OP_SWITCH, 15'h0, 1'b0, 16'h0);          // lone thread
        send_cmd(OP_CREATE, 15'h7fff, 1'b0, 16'hffff);    // join, sleeps
        send_cmd(OP_CREATE, 15'h1234, 1'b0, 16'hffff);
        send_cmd(OP_SWITCH, 15'h7fff, 1'b1, 16'h0);       // leader ignored
        send_cmd(OP_SWITCH, 15'h7fff, 1'b0, 16'h5555);    // rotate
        send_cmd(OP_CREATE, 15'h7fff, 1'b0, 16'h0);       // same tid in two groups
        send_cmd(OP_BAD, 15'h2aaa, 1'b1, 16'haaaa);       // unknown opcode
        send_cmd(OP_DELETE, 15'h1234, 1'b0, 16'h0);       // pops head, not caller
        send_cmd(OP_DELETE, 15'h0, 1'b0, 16'h0);
        send_cmd(OP_DELETE, 15'h7fff, 1'b0, 16'h0);
        send_cmd(OP_DELETE, 15'h7fff, 1'b0, 16'h0);       // no group
        send_cmd(OP_DELETE, 15'h7fff, 1'b0, 16'h0);
        // table full: 17 distinct keys, more than the free groups
        for (int i = 0; i < 17; i++)
            send_cmd(OP_CREATE, TID_W'(i), 1'b0, KEY_W'(16'h100 + i));
        drain();
    endtask

    task automatic test_fill_and_stall();
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 60; i++)
                    send_cmd(OP_CREATE, TID_W'($urandom_range(0, 32767)),
                             1'($urandom_range(0, 1)),
                             KEY_W'(16'h100 + $urandom_range(0, 3)));
                req_valid <= 1'b0;
            end
        join
        drain();
        refresh_live_tids();
        while (live_tids.size() != 0)
        begin
            send_cmd(OP_DELETE, live_tids[0], 1'b0, 16'h0);
            refresh_live_tids();
        end
        drain();
    endtask

    task automatic test_random(int n_items);
        int burst;
        int k;
        logic [1:0] op;
        k = 0;
        while (k < n_items)
        begin
            burst = $urandom_range(1, 30);
            stall_on = ($urandom_range(0, 4) != 0);
            for (int j = 0; j < burst && k < n_items; j++)
            begin
                refresh_live_tids();
                // weight toward create while the tables are sparse
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: op = OP_CREATE;
                    4, 5, 6:    op = OP_SWITCH;
                    7, 8:       op = OP_DELETE;
                    default:    op = 2'($urandom_range(0, 3));
                endcase
                if (op == OP_CREATE && live_tids.size() > 40 && $urandom_range(0, 1))
                    op = OP_DELETE;
                send_cmd(op, pick_tid(), ($urandom_range(0, 4) == 0),
                         ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 19)));
                k++;
            end
            if ($urandom_range(0, 2) == 0)
                pause_cycles($urandom_range(1, 150));
        end
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        for (int i = 0; i < MAX_THREADS; i++)
        begin
            q_thread[i] = '0;
            q_next[i] = '0;
            q_group[i] = '0;
            q_used[i] = 1'b0;
        end
        for (int i = 0; i < MAX_GROUPS; i++)
        begin
            g_key[i] = '0;
            g_head[i] = '0;
            g_tail[i] = '0;
            g_count[i] = 0;
            g_used[i] = 1'b0;
        end
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_fill_and_stall();
        test_random(1180);
        repeat (200) @(negedge clk);
        $display("Sent %0d commands, got %0d responses: %0d full, %0d no-group,",
                 n_sent, n_rcvd, n_full, n_nogrp);
        $display("  %0d wakes, %0d groups closed, including a long receiver stall",
                 n_wake, n_removed);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

/* grouped_round_robin_run_queues.f */
hw/rtl/grrq_pkg.sv
hw/rtl/grrq_ram.sv
hw/rtl/grrq_ctrl.sv
hw/rtl/grrq_dp.sv
hw/rtl/grouped_round_robin_run_queues.sv
hw/rtl/grrq_checker.sv
tb/sv/tb.sv
